[rtl/core/rcpk_pkg.sv]
// Shared types, constants and CRC lookup table for the packet check and channel decode core.
package rcpk_pkg;

   localparam int NUM_CHANNEL_WORDS = 8;
   localparam int CHANNEL_BYTES     = 12;
   localparam int IDX_W             = $clog2(NUM_CHANNEL_WORDS);
   localparam int NUM_W             = 13;
   localparam int RECIP_W           = 16;
   localparam int PROD_W            = NUM_W + RECIP_W;
   localparam int RECIP_SHIFT       = 17;
   localparam int TDATA_W           = 32;

   localparam logic [6:0]        MIN_LENGTH   = 7'd24;
   localparam logic [6:0]        MAX_LENGTH   = 7'd64;
   localparam logic [15:0]       CRC_POLY     = 16'h8408;
   localparam logic [NUM_W-1:0]  VALUE_OFFSET = 13'd2452;
   localparam logic [RECIP_W-1:0] RECIP_THREE = 16'd43691;
   localparam logic [IDX_W-1:0]  LAST_IDX     = IDX_W'(NUM_CHANNEL_WORDS - 1);

   // packet byte positions
   localparam logic [5:0] POS_LENGTH      = 6'd0;
   localparam logic [5:0] POS_BIND_FIRST  = 6'd1;
   localparam logic [5:0] POS_BIND_SECOND = 6'd2;
   localparam logic [5:0] POS_CRC_FIRST   = 6'd3;
   localparam logic [5:0] POS_RX_NUMBER   = 6'd6;
   localparam logic [5:0] POS_FAILSAFE    = 6'd7;
   localparam logic [5:0] POS_CHAN_FIRST  = 6'd9;
   localparam logic [5:0] POS_CHAN_LAST   = 6'd20;

   // configuration register indexes
   localparam logic [1:0] CSR_PACKET_LENGTH   = 2'd0;
   localparam logic [1:0] CSR_BIND_ID_FIRST   = 2'd1;
   localparam logic [1:0] CSR_BIND_ID_SECOND  = 2'd2;
   localparam logic [1:0] CSR_RECEIVER_NUMBER = 2'd3;

   typedef struct packed {
      logic [6:0] packet_length;
      logic [7:0] bind_id_first;
      logic [7:0] bind_id_second;
      logic [7:0] receiver_number;
   } rcpk_cfg_type;

   typedef struct packed {
      logic                            packet_valid;
      logic                            failsafe_packet;
      logic [7:0]                      rssi_raw;
      logic [CHANNEL_BYTES-1:0][7:0]   chan_bytes;
   } rcpk_job_type;

   typedef logic [15:0] crc_table_type [256];

   function automatic crc_table_type crc_table_build();
      crc_table_type t;
      logic [15:0]   c;
      for (int i = 0; i < 256; i++) begin
         c = 16'(i);
         for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
         end
         t[i] = c;
      end
      return t;
   endfunction

   localparam crc_table_type CRC_TABLE = crc_table_build();

endpackage

[rtl/core/rcpk_front.sv]
// Front end: byte position tracking, header and CRC checks, channel byte capture.
module rcpk_front
   import rcpk_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  rcpk_cfg_type cfg,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,
   input  logic         req_tuser,
   input  logic         q_full,
   output logic         push,
   output rcpk_job_type push_job
);

   logic [5:0]  pos_ff, pos_in;
   logic [15:0] crc_ff, crc_in;
   logic        hdr_ok_ff, hdr_ok_in;
   logic        fs_ff, fs_in;
   logic [7:0]  rssi_ff, rssi_in;
   logic        open_ff, open_in;
   logic [CHANNEL_BYTES-1:0][7:0] chan_ff, chan_in;

   logic [6:0]  eff_len;
   logic        accept;
   logic        open_cur;
   logic [5:0]  p;
   logic [6:0]  p_ext;
   logic [15:0] crc_cur;
   logic        hok;
   logic        fs;
   logic [7:0]  b;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign b          = req_tdata;

   always_comb begin
      if (cfg.packet_length < MIN_LENGTH) begin
         eff_len = MIN_LENGTH;
      end else if (cfg.packet_length > MAX_LENGTH) begin
         eff_len = MAX_LENGTH;
      end else begin
         eff_len = cfg.packet_length;
      end
   end

   always_comb begin
      open_cur  = req_tuser || open_ff;
      p         = req_tuser ? '0 : pos_ff;
      p_ext     = {1'b0, p};
      crc_cur   = req_tuser ? '0 : crc_ff;
      hok       = req_tuser ? 1'b1 : hdr_ok_ff;
      fs        = req_tuser ? 1'b0 : fs_ff;

      pos_in    = pos_ff;
      crc_in    = crc_ff;
      hdr_ok_in = hdr_ok_ff;
      fs_in     = fs_ff;
      rssi_in   = rssi_ff;
      open_in   = open_ff;
      chan_in   = chan_ff;
      push      = 1'b0;

      if (accept && open_cur) begin
         if (p == POS_LENGTH && b != (8'(eff_len) - 8'd3)) hok = 1'b0;
         if (p == POS_BIND_FIRST && b != cfg.bind_id_first) hok = 1'b0;
         if (p == POS_BIND_SECOND && b != cfg.bind_id_second) hok = 1'b0;
         if (p == POS_RX_NUMBER && cfg.receiver_number != 8'd0 && b != 8'd0 &&
             b != cfg.receiver_number) hok = 1'b0;
         if (p == POS_FAILSAFE) fs = (b != 8'd0);
         if (p >= POS_CHAN_FIRST && p <= POS_CHAN_LAST) begin
            chan_in[4'(p - POS_CHAN_FIRST)] = b;
         end
         if (p_ext == eff_len - 7'd4 && b != crc_cur[15:8]) hok = 1'b0;
         if (p_ext == eff_len - 7'd3 && b != crc_cur[7:0]) hok = 1'b0;
         if (p_ext == eff_len - 7'd2) rssi_in = b;
         if (p >= POS_CRC_FIRST && p_ext <= eff_len - 7'd5) begin
            crc_in = {crc_cur[7:0], 8'h00} ^ CRC_TABLE[crc_cur[15:8] ^ b];
         end else begin
            crc_in = crc_cur;
         end
         hdr_ok_in = hok;
         fs_in     = fs;
         open_in   = 1'b1;
         if (p_ext == eff_len - 7'd1) begin
            open_in = 1'b0;
            push    = 1'b1;
            pos_in  = p;
         end else begin
            pos_in  = p + 6'd1;
         end
      end
   end

   always_comb begin
      push_job.packet_valid    = hok;
      push_job.failsafe_packet = fs;
      push_job.rssi_raw        = rssi_ff;
      push_job.chan_bytes      = chan_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         crc_ff    <= '0;
         hdr_ok_ff <= 1'b1;
         fs_ff     <= 1'b0;
         rssi_ff   <= '0;
         open_ff   <= 1'b1;
      end else begin
         pos_ff    <= pos_in;
         crc_ff    <= crc_in;
         hdr_ok_ff <= hdr_ok_in;
         fs_ff     <= fs_in;
         rssi_ff   <= rssi_in;
         open_ff   <= open_in;
      end
   end

   always_ff @(posedge clock) begin
      chan_ff <= chan_in;
   end

endmodule

[rtl/core/rcpk_queue.sv]
// Small FIFO of packet verdicts between the front and back ends.
module rcpk_queue #(
   parameter int DEPTH = 2,
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             q_valid,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign q_valid  = (count_ff != '0);
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/core/rcpk_back.sv]
// Back end: verdict result or eight unpacked, scaled channel results per packet.
module rcpk_back
   import rcpk_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   input  rcpk_job_type       q_job,
   output logic               pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [TDATA_W-1:0] rsp_tdata,
   output logic               rsp_tuser,
   output logic               rsp_tlast
);

   rcpk_job_type     job_ff, job_in;
   logic             job_valid_ff, job_valid_in;
   logic [IDX_W-1:0] idx_ff, idx_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             pkt_valid_ff, pkt_valid_in;
   logic             fs_ff, fs_in;
   logic             present_ff, present_in;
   logic [3:0]       slot_ff, slot_in;
   logic [11:0]      value_ff, value_in;
   logic [7:0]       rssi_ff, rssi_in;
   logic             last_ff, last_in;

   logic [11:0]      words [NUM_CHANNEL_WORDS];
   logic [11:0]      w;
   logic [NUM_W-1:0] num;
   logic [PROD_W-1:0] prod;
   logic             single;
   logic             load_out;
   logic             done;

   always_comb begin
      for (int i = 0; i < NUM_CHANNEL_WORDS / 2; i++) begin
         words[2*i]   = {job_ff.chan_bytes[3*i+1][3:0], job_ff.chan_bytes[3*i]};
         words[2*i+1] = {job_ff.chan_bytes[3*i+2], job_ff.chan_bytes[3*i+1][7:4]};
      end
   end

   // (2v + 2452) / 3 via reciprocal multiply, exact below 2^16
   assign w      = words[idx_ff];
   assign num    = NUM_W'({w[10:0], 1'b0}) + VALUE_OFFSET;
   assign prod   = PROD_W'(num) * PROD_W'(RECIP_THREE);

   assign single   = !(job_ff.packet_valid && !job_ff.failsafe_packet);
   assign load_out = job_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign done     = single || (idx_ff == LAST_IDX);
   assign pop      = q_valid && (!job_valid_ff || (load_out && done));

   always_comb begin
      job_in       = job_ff;
      job_valid_in = job_valid_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      pkt_valid_in = pkt_valid_ff;
      fs_in        = fs_ff;
      present_in   = present_ff;
      slot_in      = slot_ff;
      value_in     = value_ff;
      rssi_in      = rssi_ff;
      last_in      = last_ff;

      if (load_out) begin
         rsp_valid_in = 1'b1;
         pkt_valid_in = job_ff.packet_valid;
         fs_in        = job_ff.failsafe_packet;
         rssi_in      = job_ff.rssi_raw;
         if (single) begin
            present_in = 1'b0;
            slot_in    = '0;
            value_in   = '0;
            last_in    = 1'b1;
         end else begin
            present_in = 1'b1;
            slot_in    = {w[11], idx_ff};
            value_in   = prod[RECIP_SHIFT +: 12];
            last_in    = (idx_ff == LAST_IDX);
         end
         if (done) begin
            job_valid_in = 1'b0;
            idx_in       = '0;
         end else begin
            idx_in = idx_ff + IDX_W'(1);
         end
      end

      if (pop) begin
         job_in       = q_job;
         job_valid_in = 1'b1;
         idx_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff       <= job_in;
      pkt_valid_ff <= pkt_valid_in;
      fs_ff        <= fs_in;
      present_ff   <= present_in;
      slot_ff      <= slot_in;
      value_ff     <= value_in;
      rssi_ff      <= rssi_in;
      last_ff      <= last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = present_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = TDATA_W'({rssi_ff, value_ff, slot_ff, fs_ff, pkt_valid_ff});

endmodule

[rtl/core/rc_packet_check_and_channel_decode_core.sv]
// Top level of the received packet checker and channel decoder.
//
// req_*: one packet byte per item; req_tuser high marks byte 0 of a packet.
// Bytes are taken one per cycle while req_tready is high. Bytes after the
// last of a packet are dropped until the next start marker; a start marker
// mid-packet drops the packet in progress.
// rsp_*: on the last byte a packet gives one verdict item, or, when it is
// valid and not failsafe, eight channel items (rsp_tlast on the final one).
// The first item passes from the verdict queue through the job register to
// the output register; others follow one per cycle while rsp_tready is high.
// csr_*: register writes, always ready; write only while the block is idle.
// Reset: packet length 32, ids and receiver number 0, byte count cleared.
// When rsp_tready is low the output register holds; up to QUEUE_DEPTH
// finished packets wait in the verdict queue, and req_tready drops only
// when that queue is full.
module rc_packet_check_and_channel_decode_core
   import rcpk_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,   // data_byte
   input  logic               req_tuser,   // frame_start
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   // packet_valid, failsafe_packet, channel_slot[3:0], channel_value[11:0], rssi_raw[7:0]
   output logic [TDATA_W-1:0] rsp_tdata,
   output logic               rsp_tuser,   // channel_present
   output logic               rsp_tlast,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [7:0]         csr_data
);

   rcpk_cfg_type cfg_ff, cfg_in;
   logic         push;
   rcpk_job_type push_job;
   rcpk_job_type q_job;
   logic         q_full;
   logic         q_valid;
   logic         pop;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_PACKET_LENGTH:   cfg_in.packet_length   = csr_data[6:0];
            CSR_BIND_ID_FIRST:   cfg_in.bind_id_first   = csr_data;
            CSR_BIND_ID_SECOND:  cfg_in.bind_id_second  = csr_data;
            CSR_RECEIVER_NUMBER: cfg_in.receiver_number = csr_data;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.packet_length   <= 7'd32;
         cfg_ff.bind_id_first   <= '0;
         cfg_ff.bind_id_second  <= '0;
         cfg_ff.receiver_number <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rcpk_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .push       (push),
      .push_job   (push_job)
   );

   rcpk_queue #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH ($bits(rcpk_job_type))
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_job),
      .full      (q_full),
      .pop       (pop),
      .q_valid   (q_valid),
      .pop_data  (q_job)
   );

   rcpk_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_job      (q_job),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   a_full_stalls_input: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !req_tready)
      else $error("input accepted while verdict queue full");

   a_push_fills_queue: assert property (@(posedge clock) disable iff (reset)
      push |=> q_valid)
      else $error("pushed verdict missing from queue");

   a_channel_only_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[0] && !rsp_tdata[1])
      else $error("channel item from invalid or failsafe packet");

   a_last_channel_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser && rsp_tlast |-> rsp_tdata[4:2] == 3'd7)
      else $error("final channel item not the eighth word");

endmodule
